>>> sv/playfair_cipher_encrypt_core_assert.svh
// ----------------------------------------------------------------------------
// Playfair encryptor assertion macros
// Concurrent check wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef PLAYFAIR_CIPHER_ENCRYPT_CORE_ASSERT_SVH
`define PLAYFAIR_CIPHER_ENCRYPT_CORE_ASSERT_SVH

`ifndef SYNTH

// prop must hold at every clock edge outside reset
`define PFE_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("pfe check failed");

// cond must never be true outside reset
`define PFE_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("pfe forbidden condition");

`else

`define PFE_ASSERT(lbl, clk, rstn, prop)
`define PFE_NEVER(lbl, clk, rstn, cond)

`endif

`endif

>>> sv/pfe_pkg.sv
// ----------------------------------------------------------------------------
// pfe_pkg
// Types, constants and helpers shared by the Playfair encryptor modules.
// ----------------------------------------------------------------------------
package pfe_pkg;

    localparam int SQUARE_SIDE    = 5;
    localparam int CELL_COUNT     = SQUARE_SIDE * SQUARE_SIDE;
    localparam int ALPHABET       = 26;
    localparam int LETTER_W       = 5;
    localparam int CELL_W         = $clog2(CELL_COUNT);
    localparam int RC_W           = $clog2(SQUARE_SIDE);
    localparam int QUEUE_DEPTH_DEF = 4;

    typedef logic [LETTER_W-1:0] letter_t;
    typedef logic [CELL_W-1:0]   cell_t;
    typedef logic [RC_W-1:0]     rc_t;

    localparam letter_t CODE_I    = letter_t'(8);
    localparam letter_t CODE_J    = letter_t'(9);
    localparam letter_t CODE_LAST = letter_t'(ALPHABET - 1);
    localparam letter_t PAD_RESET = letter_t'(23);

    typedef enum logic [1:0] {
        CMD_KEY     = 2'd0,
        CMD_KEY_END = 2'd1,
        CMD_MSG     = 2'd2,
        CMD_MSG_END = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        OP_PLACE = 2'd0,
        OP_FILL  = 2'd1,
        OP_ENC   = 2'd2
    } op_kind_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_FILL,
        BK_POSA,
        BK_POSB,
        BK_OUT1,
        BK_OUT2
    } bk_state_t;

    typedef struct packed {
        logic [1:0] command;
        letter_t    letter;
    } in_item_t;

    typedef struct packed {
        letter_t cipher_letter;
        logic    pair_last;
    } out_item_t;

    typedef struct packed {
        op_kind_t kind;
        letter_t  a;
        letter_t  b;
    } op_t;

    function automatic letter_t fold_j(letter_t c);
        return (c == CODE_J) ? CODE_I : c;
    endfunction

    // row of a cell index, by compares against multiples of the side
    function automatic rc_t cell_row(cell_t p);
        rc_t r;
        r = '0;
        for (int k = 1; k < SQUARE_SIDE; k++) begin
            if (p >= cell_t'(k * SQUARE_SIDE)) begin
                r = rc_t'(k);
            end
        end
        return r;
    endfunction

    function automatic rc_t cell_col(cell_t p, rc_t r);
        return rc_t'(p - cell_t'(r) * cell_t'(SQUARE_SIDE));
    endfunction

    function automatic rc_t wrap_inc(rc_t x);
        return (x == rc_t'(SQUARE_SIDE - 1)) ? '0 : rc_t'(x + 1'b1);
    endfunction

    function automatic cell_t cell_index(rc_t r, rc_t c);
        return cell_t'(r) * cell_t'(SQUARE_SIDE) + cell_t'(c);
    endfunction

endpackage

>>> sv/playfair_cipher_encrypt_core.sv
// ----------------------------------------------------------------------------
// playfair_cipher_encrypt_core
// Playfair encryptor: key square build, key-end fill and pair encryption.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes command items (key letter, key end, message letter,
//   message end) with valid/ready. m_* channel returns cipher letters, two
//   per encrypted pair, pair_last set on the second one.
//   cfg_wr_en/cfg_wr_data write the pad letter used at message end.
// Timing:
//   The front part takes one item per cycle while the op queue has room.
//   The back part handles a key letter as it takes the op; on key end it
//   takes the op, then one alphabet letter per cycle. A pair goes
//   through two position reads and two square reads; the next op waits
//   until both cipher letters are loaded. The first enters the output register
//   in BK_OUT1, the second in BK_OUT2 once the receiver has taken the first.
// Reset clears the key (all letters unused, no cells filled), the held
//   letter and the queue, and sets the pad letter to X.
// A stalled receiver holds the output register; the back part waits and
//   the queue fills, after which s_ready drops.
// ----------------------------------------------------------------------------
module playfair_cipher_encrypt_core #(
    parameter int QUEUE_DEPTH = pfe_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  pfe_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output pfe_pkg::out_item_t m_data,
    input  logic               cfg_wr_en,
    input  pfe_pkg::letter_t   cfg_wr_data
);
    import pfe_pkg::*;

    logic q_push, q_full, q_pop, q_empty;
    op_t  push_op, head_op;

    pfe_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_op        (push_op)
    );

    pfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .push_op (push_op),
        .full    (q_full),
        .pop     (q_pop),
        .head_op (head_op),
        .empty   (q_empty)
    );

    pfe_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_op    (head_op),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

>>> sv/pfe_ram.sv
// ----------------------------------------------------------------------------
// pfe_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pfe_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/pfe_queue.sv
// ----------------------------------------------------------------------------
// pfe_queue
// Small op queue between the front and back parts.
// ----------------------------------------------------------------------------
`include "playfair_cipher_encrypt_core_assert.svh"

module pfe_queue #(
    parameter int DEPTH = pfe_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  pfe_pkg::op_t  push_op,
    output logic          full,
    input  logic          pop,
    output pfe_pkg::op_t  head_op,
    output logic          empty
);
    import pfe_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    op_t              mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign head_op = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        // pointers wrap at the last entry, so non-power-of-two depths work
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                           : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                           : PTR_W'(rd_ptr_reg + 1'b1);
        end
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = CNT_W'(count_reg + 1'b1);
        end else if (pop && !push) begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_op;
        end
    end

    `PFE_NEVER(a_no_push_full, aclk, aresetn, push && full)
    `PFE_NEVER(a_no_pop_empty, aclk, aresetn, pop && empty)
    `PFE_ASSERT(a_count_up, aclk, aresetn, (push && !pop) |=> (count_reg == CNT_W'($past(count_reg) + 1'b1)))

endmodule

>>> sv/pfe_front.sv
// ----------------------------------------------------------------------------
// pfe_front
// Accepts items, folds J, pairs message letters and queues back-end ops.
// ----------------------------------------------------------------------------
module pfe_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pfe_pkg::in_item_t s_data,
    input  logic              cfg_wr_en,
    input  pfe_pkg::letter_t  cfg_wr_data,
    input  logic              q_full,
    output logic              q_push,
    output pfe_pkg::op_t      q_op
);
    import pfe_pkg::*;

    logic    held_valid_reg, held_valid_next;
    letter_t held_letter_reg, held_letter_next;
    letter_t pad_reg, pad_next;

    logic    accept;
    logic    in_range;
    letter_t in_letter;
    letter_t pad_letter;

    assign s_ready   = !q_full;
    assign accept    = s_valid && !q_full;
    assign in_range  = (s_data.letter <= CODE_LAST);
    assign in_letter = fold_j(s_data.letter);
    // out-of-range pad saturates to Z
    assign pad_letter = fold_j((pad_reg > CODE_LAST) ? CODE_LAST : pad_reg);

    always_comb begin
        q_push           = 1'b0;
        q_op             = '{kind: OP_PLACE, a: in_letter, b: in_letter};
        held_valid_next  = held_valid_reg;
        held_letter_next = held_letter_reg;
        pad_next         = cfg_wr_en ? cfg_wr_data : pad_reg;
        if (accept) begin
            unique case (cmd_t'(s_data.command))
                CMD_KEY: begin
                    q_push = in_range;
                end
                CMD_KEY_END: begin
                    q_push = 1'b1;
                    q_op   = '{kind: OP_FILL, a: in_letter, b: in_letter};
                end
                CMD_MSG: begin
                    if (in_range) begin
                        if (!held_valid_reg) begin
                            held_valid_next  = 1'b1;
                            held_letter_next = in_letter;
                        end else begin
                            held_valid_next = 1'b0;
                            q_push          = 1'b1;
                            q_op = '{kind: OP_ENC, a: held_letter_reg, b: in_letter};
                        end
                    end
                end
                CMD_MSG_END: begin
                    if (held_valid_reg) begin
                        held_valid_next = 1'b0;
                        q_push          = 1'b1;
                        q_op = '{kind: OP_ENC, a: held_letter_reg, b: pad_letter};
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_valid_reg  <= 1'b0;
            held_letter_reg <= '0;
            pad_reg         <= PAD_RESET;
        end else begin
            held_valid_reg  <= held_valid_next;
            held_letter_reg <= held_letter_next;
            pad_reg         <= pad_next;
        end
    end

endmodule

>>> sv/pfe_back.sv
// ----------------------------------------------------------------------------
// pfe_back
// Owns the key square: places letters, runs the key-end fill and encrypts
// pairs into the output register.
// ----------------------------------------------------------------------------
`include "playfair_cipher_encrypt_core_assert.svh"

module pfe_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_empty,
    input  pfe_pkg::op_t       q_op,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output pfe_pkg::out_item_t m_data
);
    import pfe_pkg::*;

    bk_state_t             state_reg, state_next;
    logic [ALPHABET-1:0]   used_reg, used_next;
    logic [CELL_W:0]       fill_count_reg, fill_count_next;
    letter_t               fill_idx_reg, fill_idx_next;
    letter_t               b_reg, b_next;
    cell_t                 pa_reg, pa_next;
    cell_t                 idx2_reg, idx2_next;
    logic                  m_valid_reg, m_valid_next;
    out_item_t             m_data_reg, m_data_next;

    // square and position stores
    logic    sq_re, pos_re;
    cell_t   sq_raddr;
    letter_t pos_raddr;
    letter_t sq_rdata;
    cell_t   pos_rdata;

    logic    place_req, do_place;
    letter_t place_letter;
    logic    out_free, out_load, out_last;

    cell_t pb;
    rc_t   r1, c1, r2, c2;
    cell_t idx1, idx2;

    assign out_free = !m_valid_reg || m_ready;

    // pair geometry from the two looked-up positions
    always_comb begin
        pb = pos_rdata;
        r1 = cell_row(pa_reg);
        c1 = cell_col(pa_reg, r1);
        r2 = cell_row(pb);
        c2 = cell_col(pb, r2);
        if (r1 == r2) begin
            idx1 = cell_index(r1, wrap_inc(c1));
            idx2 = cell_index(r1, wrap_inc(c2));
        end else if (c1 == c2) begin
            idx1 = cell_index(wrap_inc(r1), c1);
            idx2 = cell_index(wrap_inc(r2), c1);
        end else begin
            idx1 = cell_index(r1, c2);
            idx2 = cell_index(r2, c1);
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (!q_empty) begin
                    unique case (q_op.kind)
                        OP_FILL: state_next = BK_FILL;
                        OP_ENC:  state_next = BK_POSA;
                        default: state_next = BK_IDLE;
                    endcase
                end
            end
            BK_FILL: begin
                if (fill_idx_reg == CODE_LAST) begin
                    state_next = BK_IDLE;
                end
            end
            BK_POSA: state_next = BK_POSB;
            BK_POSB: state_next = BK_OUT1;
            BK_OUT1: begin
                if (out_free) begin
                    state_next = BK_OUT2;
                end
            end
            BK_OUT2: begin
                if (out_free) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        q_pop        = 1'b0;
        place_req    = 1'b0;
        place_letter = fill_idx_reg;
        fill_idx_next = fill_idx_reg;
        b_next       = b_reg;
        pa_next      = pa_reg;
        idx2_next    = idx2_reg;
        pos_re       = 1'b0;
        pos_raddr    = b_reg;
        sq_re        = 1'b0;
        sq_raddr     = idx2_reg;
        out_load     = 1'b0;
        out_last     = 1'b0;
        unique case (state_reg)
            BK_IDLE: begin
                q_pop         = !q_empty;
                fill_idx_next = '0;
                if (!q_empty) begin
                    unique case (q_op.kind)
                        OP_PLACE: begin
                            place_req    = 1'b1;
                            place_letter = q_op.a;
                        end
                        OP_ENC: begin
                            pos_re    = 1'b1;
                            pos_raddr = q_op.a;
                            b_next    = q_op.b;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            BK_FILL: begin
                place_req     = (fill_idx_reg != CODE_J);
                fill_idx_next = letter_t'(fill_idx_reg + 1'b1);
            end
            BK_POSA: begin
                pos_re  = 1'b1;
                pa_next = pos_rdata;
            end
            BK_POSB: begin
                sq_re     = 1'b1;
                sq_raddr  = idx1;
                idx2_next = idx2;
            end
            BK_OUT1: begin
                // read data holds until the slot frees up
                if (out_free) begin
                    out_load = 1'b1;
                    sq_re    = 1'b1;
                end
            end
            BK_OUT2: begin
                out_load = out_free;
                out_last = 1'b1;
            end
            default: begin
            end
        endcase

        do_place = place_req && !used_reg[place_letter]
                   && (fill_count_reg < (CELL_W + 1)'(CELL_COUNT));
        used_next       = used_reg;
        fill_count_next = fill_count_reg;
        if (do_place) begin
            used_next[place_letter] = 1'b1;
            fill_count_next = (CELL_W + 1)'(fill_count_reg + 1'b1);
        end

        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (out_load) begin
            m_valid_next = 1'b1;
            m_data_next  = '{cipher_letter: sq_rdata, pair_last: out_last};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= BK_IDLE;
            used_reg       <= '0;
            fill_count_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            fill_count_reg <= fill_count_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        fill_idx_reg <= fill_idx_next;
        b_reg        <= b_next;
        pa_reg       <= pa_next;
        idx2_reg     <= idx2_next;
        m_data_reg   <= m_data_next;
    end

    pfe_ram #(
        .WIDTH (LETTER_W),
        .DEPTH (CELL_COUNT)
    ) u_square (
        .aclk  (aclk),
        .we    (do_place),
        .waddr (cell_t'(fill_count_reg)),
        .wdata (place_letter),
        .re    (sq_re),
        .raddr (sq_raddr),
        .rdata (sq_rdata)
    );

    pfe_ram #(
        .WIDTH (CELL_W),
        .DEPTH (ALPHABET)
    ) u_position (
        .aclk  (aclk),
        .we    (do_place),
        .waddr (place_letter),
        .wdata (cell_t'(fill_count_reg)),
        .re    (pos_re),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `PFE_ASSERT(a_used_matches_fill, aclk, aresetn, $countones(used_reg) == int'(fill_count_reg))
    `PFE_NEVER(a_fill_bound, aclk, aresetn, fill_count_reg > (CELL_W + 1)'(CELL_COUNT))
    `PFE_ASSERT(a_out2_after_out1, aclk, aresetn, (state_reg == BK_OUT2) |-> ($past(state_reg) == BK_OUT1 || $past(state_reg) == BK_OUT2))
    `PFE_ASSERT(a_second_has_last, aclk, aresetn, (out_load && state_reg == BK_OUT2) |=> m_data_reg.pair_last)

endmodule
